// ===== rtl/stack_of_integer_records_defines.svh =====
// ---------------------------------------------------------------------------
// stack_of_integer_records assertion macros
// shared checks for the record stack, sampled on clk, off during reset
// ---------------------------------------------------------------------------
`ifndef STACK_OF_INTEGER_RECORDS_DEFINES_SVH
`define STACK_OF_INTEGER_RECORDS_DEFINES_SVH

// same-cycle implication
`define SOIR_ASSERT_NOW(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("stack_of_integer_records: same-cycle check failed");

// next-cycle implication
`define SOIR_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("stack_of_integer_records: next-cycle check failed");

`endif

// ===== rtl/soir_pkg.sv =====
// ---------------------------------------------------------------------------
// soir_pkg
// command codes and the classified operation passed from front to back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package soir_pkg;

    localparam logic [1:0] CMD_CHAR = 2'd0;
    localparam logic [1:0] CMD_EOL  = 2'd1;
    localparam logic [1:0] CMD_POP  = 2'd2;

    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [31:0] CH_ZERO = 32'd48;

    typedef enum logic [1:0] {
        OP_DIGIT,
        OP_SPACE,
        OP_EOL,
        OP_POP
    } op_kind_t;

    typedef struct packed {
        op_kind_t   kind;
        logic [7:0] ch;
    } op_t;

endpackage

// ===== rtl/soir_front.sv =====
// ---------------------------------------------------------------------------
// soir_front
// accepts requests and classifies them into operations for the queue
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module soir_front (
    input  logic             start,
    input  logic             full,
    input  logic [1:0]       cmd,
    input  logic [7:0]       ch,
    output logic             push,
    output soir_pkg::op_t    item
);
    import soir_pkg::*;

    logic known;

    always_comb
    begin
        known     = 1'b1;
        item.ch   = ch;
        item.kind = OP_DIGIT;
        case (cmd)
            CMD_CHAR: item.kind = (ch == CH_SPACE) ? OP_SPACE : OP_DIGIT;
            CMD_EOL:  item.kind = OP_EOL;
            CMD_POP:  item.kind = OP_POP;
            default:  known     = 1'b0;
        endcase
    end

    // unused command code is taken but dropped here
    assign push = start && !full && known;

endmodule

// ===== rtl/soir_queue.sv =====
// ---------------------------------------------------------------------------
// soir_queue
// two-entry queue of classified operations between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module soir_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  soir_pkg::op_t    push_item,
    input  logic             pop,
    output soir_pkg::op_t    pop_item,
    output logic             nonempty,
    output logic             full
);
    import soir_pkg::*;

    op_t        slot_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;
    logic       do_pop;

    assign nonempty = (count_reg != 2'd0);
    assign full     = (count_reg == 2'd2);
    assign pop_item = slot_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/soir_back.sv =====
// ---------------------------------------------------------------------------
// soir_back
// builds numbers, commits records and streams popped records out
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module soir_back #(
    parameter int WORD_DEPTH  = 1024,
    parameter int STACK_DEPTH = 64,
    parameter int RECORD_MAX  = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  soir_pkg::op_t    q_item,
    output logic             q_pop,
    output logic             strobe,
    output logic [31:0]      value,
    output logic             empty_res,
    output logic             last
);
    import soir_pkg::*;

    localparam int WP_W  = $clog2(WORD_DEPTH + 1);
    localparam int WA_W  = $clog2(WORD_DEPTH);
    localparam int LEN_W = (RECORD_MAX > 1) ? $clog2(RECORD_MAX + 1) : 1;
    localparam int RC_W  = $clog2(STACK_DEPTH + 1);
    localparam int SA_W  = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LEN,
        S_STREAM
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [WP_W-1:0]    wp_reg;
    logic [WP_W-1:0]    wp_next;
    logic [RC_W-1:0]    rc_reg;
    logic [RC_W-1:0]    rc_next;
    logic [31:0]        acc_reg;
    logic [31:0]        acc_next;
    logic [LEN_W-1:0]   cur_len_reg;
    logic [LEN_W-1:0]   cur_len_next;
    logic               started_reg;
    logic               started_next;
    logic [WA_W-1:0]    rd_addr_reg;
    logic [WA_W-1:0]    rd_addr_next;
    logic [LEN_W-1:0]   remain_reg;
    logic [LEN_W-1:0]   remain_next;
    logic               strobe_reg;
    logic               strobe_next;
    logic               empty_reg;
    logic               empty_next;
    logic               last_reg;
    logic               last_next;

    logic [31:0]        word_mem [WORD_DEPTH];
    logic [LEN_W-1:0]   len_mem [STACK_DEPTH];
    logic [31:0]        word_q;
    logic [LEN_W-1:0]   len_q;

    logic               word_we;
    logic [WA_W-1:0]    word_waddr;
    logic               len_we;
    logic [SA_W-1:0]    len_waddr;
    logic [LEN_W-1:0]   len_wdata;
    logic [SA_W-1:0]    len_raddr;
    logic [RC_W-1:0]    rc_dec;

    logic [WP_W:0]      tok_slot;
    logic               tok_ok;
    logic [LEN_W-1:0]   len_after;
    logic [31:0]        acc_step;
    logic [WP_W-1:0]    base;

    // slot of the token being closed, and whether it fits
    assign tok_slot  = {1'b0, wp_reg} + (WP_W + 1)'(cur_len_reg);
    assign tok_ok    = (cur_len_reg < LEN_W'(RECORD_MAX))
                       && (tok_slot < (WP_W + 1)'(WORD_DEPTH));
    // acc*10 + ch - '0', all modulo 2^32
    assign acc_step  = (acc_reg << 3) + (acc_reg << 1) + {24'd0, q_item.ch} - CH_ZERO;
    assign rc_dec    = rc_reg - RC_W'(1);
    assign len_raddr = rc_dec[SA_W-1:0];
    assign base      = wp_reg - WP_W'(len_q);
    assign word_waddr = tok_slot[WA_W-1:0];
    assign len_waddr = rc_reg[SA_W-1:0];

    assign q_pop     = q_valid && (state_reg == S_IDLE);
    assign strobe    = strobe_reg;
    assign empty_res = empty_reg;
    assign last      = last_reg;
    assign value     = empty_reg ? 32'd0 : word_q;

    always_comb
    begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        rc_next      = rc_reg;
        acc_next     = acc_reg;
        cur_len_next = cur_len_reg;
        started_next = started_reg;
        rd_addr_next = rd_addr_reg;
        remain_next  = remain_reg;
        strobe_next  = 1'b0;
        empty_next   = 1'b0;
        last_next    = 1'b0;
        word_we      = 1'b0;
        len_we       = 1'b0;
        len_after    = cur_len_reg;
        len_wdata    = cur_len_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_item.kind)
                        OP_DIGIT:
                        begin
                            started_next = 1'b1;
                            acc_next     = acc_step;
                        end
                        OP_SPACE:
                        begin
                            started_next = 1'b1;
                            acc_next     = 32'd0;
                            word_we      = tok_ok;
                            if (tok_ok)
                            begin
                                cur_len_next = cur_len_reg + LEN_W'(1);
                            end
                        end
                        OP_EOL:
                        begin
                            if (started_reg && tok_ok)
                            begin
                                word_we   = 1'b1;
                                len_after = cur_len_reg + LEN_W'(1);
                            end
                            len_wdata = len_after;
                            // stack full drops the whole line
                            if (rc_reg < RC_W'(STACK_DEPTH))
                            begin
                                len_we  = 1'b1;
                                rc_next = rc_reg + RC_W'(1);
                                wp_next = wp_reg + WP_W'(len_after);
                            end
                            acc_next     = 32'd0;
                            cur_len_next = '0;
                            started_next = 1'b0;
                        end
                        OP_POP:
                        begin
                            // open line is discarded first
                            acc_next     = 32'd0;
                            cur_len_next = '0;
                            started_next = 1'b0;
                            if (rc_reg == '0)
                            begin
                                strobe_next = 1'b1;
                                empty_next  = 1'b1;
                                last_next   = 1'b1;
                            end
                            else
                            begin
                                rc_next    = rc_dec;
                                state_next = S_LEN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_LEN:
            begin
                if (len_q == '0)
                begin
                    strobe_next = 1'b1;
                    empty_next  = 1'b1;
                    last_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    wp_next      = base;
                    rd_addr_next = base[WA_W-1:0];
                    remain_next  = len_q;
                    state_next   = S_STREAM;
                end
            end
            S_STREAM:
            begin
                // read issued now, data shows on the next cycle
                strobe_next  = 1'b1;
                last_next    = (remain_reg == LEN_W'(1));
                rd_addr_next = rd_addr_reg + WA_W'(1);
                remain_next  = remain_reg - LEN_W'(1);
                if (remain_reg == LEN_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            wp_reg      <= '0;
            rc_reg      <= '0;
            acc_reg     <= 32'd0;
            cur_len_reg <= '0;
            started_reg <= 1'b0;
            rd_addr_reg <= '0;
            remain_reg  <= '0;
            strobe_reg  <= 1'b0;
            empty_reg   <= 1'b0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            rc_reg      <= rc_next;
            acc_reg     <= acc_next;
            cur_len_reg <= cur_len_next;
            started_reg <= started_next;
            rd_addr_reg <= rd_addr_next;
            remain_reg  <= remain_next;
            strobe_reg  <= strobe_next;
            empty_reg   <= empty_next;
            last_reg    <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word_we)
        begin
            word_mem[word_waddr] <= acc_reg;
        end
        word_q <= word_mem[rd_addr_reg];
    end

    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        len_q <= len_mem[len_raddr];
    end

endmodule

// ===== rtl/stack_of_integer_records.sv =====
// ---------------------------------------------------------------------------
// stack_of_integer_records
// lifo stack of variable-length records of 32-bit numbers
// ---------------------------------------------------------------------------
//  channel   handshake              payload
//  request   start / busy           cmd, ch
//  result    strobe (no stall)      value, empty_res, last
//
//  a line character or end of line is handled by the back end while idle
//  a pop does one length read, then one word read per cycle;
//  an empty stack answers from idle, an empty record after its length read
//  results stream one per cycle from the word memory
//  busy is high while the two-entry request queue is full
//  reset clears the control registers only; the memories need no clearing
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "stack_of_integer_records_defines.svh"

module stack_of_integer_records #(
    parameter int WORD_DEPTH  = 1024,
    parameter int STACK_DEPTH = 64,
    parameter int RECORD_MAX  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [7:0]  ch,
    output logic        strobe,
    output logic [31:0] value,
    output logic        empty_res,
    output logic        last
);
    import soir_pkg::*;

    logic push;
    op_t  push_item;
    logic q_pop;
    op_t  q_item;
    logic q_valid;

    soir_front u_front (
        .start (start),
        .full  (busy),
        .cmd   (cmd),
        .ch    (ch),
        .push  (push),
        .item  (push_item)
    );

    soir_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (q_pop),
        .pop_item  (q_item),
        .nonempty  (q_valid),
        .full      (busy)
    );

    soir_back #(
        .WORD_DEPTH  (WORD_DEPTH),
        .STACK_DEPTH (STACK_DEPTH),
        .RECORD_MAX  (RECORD_MAX)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .strobe    (strobe),
        .value     (value),
        .empty_res (empty_res),
        .last      (last)
    );

    // an empty result always ends its pop
    `SOIR_ASSERT_NOW(a_empty_is_last, strobe && empty_res, last)
    // an empty result carries zero
    `SOIR_ASSERT_NOW(a_empty_zero, strobe && empty_res, value == 32'd0)
    // a record streams without gaps until its last number
    `SOIR_ASSERT_NEXT(a_stream_gapless, strobe && !last, strobe && !empty_res)

endmodule

// ===== tb/stack_of_integer_records_checker.sv =====
// ---------------------------------------------------------------------------
// stack_of_integer_records_checker
// watches the request and result ports, keeps its own copy of the record
// stack, and compares each popped number against the expected one in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module stack_of_integer_records_checker #(
    parameter int WORD_DEPTH  = 1024,
    parameter int STACK_DEPTH = 64,
    parameter int RECORD_MAX  = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  cmd,
    input  logic [7:0]  ch,
    input  logic        strobe,
    input  logic [31:0] value,
    input  logic        empty_res,
    input  logic        last,
    output int          mismatches,
    output int          awaited
);
    import soir_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        empty_res;
        logic        last;
    } popped_word_t;

    popped_word_t popped_q[$];

    logic [31:0] word_mem [WORD_DEPTH];
    logic [6:0]  rec_len  [STACK_DEPTH];
    int unsigned word_top;
    int unsigned rec_top;
    int unsigned open_len;
    logic [31:0] number;
    bit          line_open;

    task automatic clear_line();
        number    = '0;
        open_len  = 0;
        line_open = 1'b0;
    endtask

    // a token beyond the record or the store capacity is lost
    task automatic close_number();
        if (open_len < RECORD_MAX && word_top + open_len < WORD_DEPTH)
        begin
            word_mem[word_top + open_len] = number;
            open_len++;
        end
        number = '0;
    endtask

    task automatic apply_request(input logic [1:0] c, input logic [7:0] x);
        int unsigned n;
        int unsigned base;
        case (c)
            CMD_CHAR:
            begin
                line_open = 1'b1;
                if (x == CH_SPACE)
                    close_number();
                else
                    number = number * 32'd10 + ({24'd0, x} - CH_ZERO);
            end
            CMD_EOL:
            begin
                if (line_open)
                    close_number();
                // full stack drops the whole line
                if (rec_top < STACK_DEPTH)
                begin
                    rec_len[rec_top] = open_len[6:0];
                    rec_top++;
                    word_top += open_len;
                end
                clear_line();
            end
            CMD_POP:
            begin
                clear_line();
                if (rec_top == 0)
                begin
                    popped_q.push_back('{value: '0, empty_res: 1'b1, last: 1'b1});
                end
                else
                begin
                    rec_top--;
                    n = rec_len[rec_top];
                    if (n > word_top)
                        n = word_top;
                    if (n > RECORD_MAX)
                        n = RECORD_MAX;
                    if (n == 0)
                    begin
                        popped_q.push_back('{value: '0, empty_res: 1'b1, last: 1'b1});
                    end
                    else
                    begin
                        base = word_top - n;
                        for (int unsigned i = 0; i < n; i++)
                            popped_q.push_back('{value: word_mem[base + i], empty_res: 1'b0,
                                                 last: (i + 1 == n)});
                        word_top = base;
                    end
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        popped_word_t want;
        if (!rst_n)
        begin
            popped_q.delete();
            word_top   = 0;
            rec_top    = 0;
            mismatches = 0;
            clear_line();
        end
        else
        begin
            // results always stem from requests taken at earlier edges
            if (strobe)
            begin
                if (popped_q.size() == 0)
                begin
                    $error("result with no pop pending: value %0d empty_res %0b last %0b",
                           value, empty_res, last);
                    mismatches++;
                end
                else
                begin
                    want = popped_q.pop_front();
                    if (value !== want.value)
                    begin
                        $error("value: expected %0d, actual %0d", want.value, value);
                        mismatches++;
                    end
                    if (empty_res !== want.empty_res)
                    begin
                        $error("empty_res: expected %0b, actual %0b", want.empty_res, empty_res);
                        mismatches++;
                    end
                    if (last !== want.last)
                    begin
                        $error("last: expected %0b, actual %0b", want.last, last);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
                apply_request(cmd, ch);
        end
        awaited = popped_q.size();
    end

endmodule

// ===== tb/tb_stack_of_integer_records.sv =====
// ---------------------------------------------------------------------------
// tb_stack_of_integer_records
// drives push lines and pops into the record stack: a directed opening,
// a record and stack fill past capacity, then random lines, pops and noise
// with bursts of idle cycles; the checker does the scoring
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_stack_of_integer_records;
    import soir_pkg::*;

    localparam logic [1:0] CMD_NOP = 2'd3;
    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_ITEMS = 80;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  cmd;
    logic [7:0]  ch;
    logic        strobe;
    logic [31:0] value;
    logic        empty_res;
    logic        last;

    int mismatches;
    int awaited;
    int sent;
    int idle_pct;

    stack_of_integer_records u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .ch        (ch),
        .strobe    (strobe),
        .value     (value),
        .empty_res (empty_res),
        .last      (last)
    );

    stack_of_integer_records_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .ch         (ch),
        .strobe     (strobe),
        .value      (value),
        .empty_res  (empty_res),
        .last       (last),
        .mismatches (mismatches),
        .awaited    (awaited)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    task automatic maybe_idle();
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clk);
        end
    endtask

    task automatic issue(input logic [1:0] c, input logic [7:0] x);
        @(negedge clk);
        start <= 1'b1;
        cmd   <= c;
        ch    <= x;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
        maybe_idle();
    endtask

    // one push line of ntok tokens, mostly decimal digits, the odd stray byte
    task automatic send_line(input int ntok, input int max_digits);
        int nd;
        for (int t = 0; t < ntok; t++)
        begin
            if (t > 0)
                issue(CMD_CHAR, CH_SPACE);
            nd = $urandom_range(0, max_digits);
            repeat (nd)
            begin
                if ($urandom_range(0, 19) == 0)
                    issue(CMD_CHAR, 8'($urandom_range(0, 255)));
                else
                    issue(CMD_CHAR, CH_ZERO[7:0] + 8'($urandom_range(0, 9)));
            end
        end
        issue(CMD_EOL, 8'($urandom_range(0, 255)));
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (awaited != 0)
            @(negedge clk);
    endtask

    initial
    begin
        int stop_at;
        int mode_at;
        int pick;
        rst_n    = 1'b0;
        start    = 1'b0;
        cmd      = CMD_CHAR;
        ch       = '0;
        sent     = 0;
        idle_pct = 30;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // pop on empty stack, empty line, line of one space, odd bytes
        issue(CMD_POP, 8'h00);
        issue(CMD_EOL, 8'hFF);
        issue(CMD_POP, 8'hFF);
        issue(CMD_CHAR, CH_SPACE);
        issue(CMD_EOL, 8'h00);
        issue(CMD_POP, 8'h00);
        issue(CMD_CHAR, 8'hFF);
        issue(CMD_CHAR, 8'h00);
        issue(CMD_CHAR, CH_ZERO[7:0] + 8'd9);
        issue(CMD_NOP, 8'hA5);
        issue(CMD_CHAR, CH_SPACE);
        issue(CMD_CHAR, CH_ZERO[7:0] + 8'd4);
        issue(CMD_EOL, 8'h5A);
        issue(CMD_POP, 8'h00);
        // pop while a line is open throws away the partial line
        issue(CMD_CHAR, CH_ZERO[7:0] + 8'd7);
        issue(CMD_EOL, 8'h00);
        issue(CMD_CHAR, CH_ZERO[7:0] + 8'd5);
        issue(CMD_POP, 8'h00);
        issue(CMD_POP, 8'h00);
        drain();

        // overfill one record, then the stack itself
        idle_pct = 5;
        send_line(66, 1);
        repeat (63) issue(CMD_EOL, 8'h00);
        send_line(3, 3);
        repeat (66) issue(CMD_POP, 8'($urandom_range(0, 255)));
        drain();

        stop_at = sent + RANDOM_ITEMS;
        mode_at = sent;
        while (sent < stop_at)
        begin
            if (sent >= mode_at)
            begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 15;
                    default: idle_pct = 50;
                endcase
                mode_at = sent + 40;
            end
            if (sent >= stop_at - 30)
                idle_pct = 0;
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                send_line($urandom_range(0, 5), 11);
            end
            else if (pick < 85)
            begin
                issue(CMD_POP, 8'($urandom_range(0, 255)));
            end
            else if (pick < 93)
            begin
                issue(CMD_NOP, 8'($urandom_range(0, 255)));
            end
            else
            begin
                // broken line cut short by a pop
                repeat ($urandom_range(1, 4))
                    issue(CMD_CHAR, CH_ZERO[7:0] + 8'($urandom_range(0, 9)));
                issue(CMD_POP, 8'($urandom_range(0, 255)));
            end
        end

        drain();
        repeat (100) @(negedge clk);
        if (mismatches == 0)
            $display("tb_stack_of_integer_records OK");
        else
            $display("tb_stack_of_integer_records NOT OK");
        $finish;
    end

    // ends the run if neither a request nor a result moves for too long
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || strobe)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb_stack_of_integer_records NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/soir_pkg.sv
rtl/soir_front.sv
rtl/soir_queue.sv
rtl/soir_back.sv
rtl/stack_of_integer_records.sv
tb/stack_of_integer_records_checker.sv
tb/tb_stack_of_integer_records.sv
